// ----- src/tlv_stream_walker_defines.svh -----
// Assertion macros for the TLV stream walker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TLV_STREAM_WALKER_DEFINES_SVH
`define TLV_STREAM_WALKER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TSW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define TSW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ----- src/tsw_pkg.sv -----
package tsw_pkg;

	// Fixed field widths
	localparam int unsigned FLEN_W  = 12;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned IDX_W   = 11;
	localparam int unsigned CNT_W   = 10;
	localparam int unsigned KIND_W  = 2;

	localparam int unsigned FLEN_MAX        = (1 << FLEN_W) - 1;
	localparam int unsigned FRAME_BYTES_DEF = 2048;
	localparam int unsigned HDR_BYTES       = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Request opcodes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Record kinds
	localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ZERO    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

	typedef enum logic [1:0] {
		PH_TYPE,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_VALUE
	} phase_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] elem_type;
		logic [LEN_W-1:0]  decl_length;
		logic [IDX_W-1:0]  value_index;
		logic [IDX_W-1:0]  elem_offset;
		logic [BYTE_W-1:0] value_byte;
		logic              value_last;
		logic              status;
		logic [CNT_W-1:0]  elem_count;
	} rec_t;

endpackage

// ----- src/tlv_byte_if.sv -----
interface tlv_byte_if;
	import tsw_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [BYTE_W-1:0] data_byte;
	logic [FLEN_W-1:0] frame_length;

	modport source (output valid, output op, output data_byte, output frame_length,
		input ready);
	modport sink (input valid, input op, input data_byte, input frame_length,
		output ready);
endinterface

interface tlv_rec_if;
	import tsw_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] elem_type;
	logic [LEN_W-1:0]  decl_length;
	logic [IDX_W-1:0]  value_index;
	logic [IDX_W-1:0]  elem_offset;
	logic [BYTE_W-1:0] value_byte;
	logic              value_last;
	logic              status;
	logic [CNT_W-1:0]  elem_count;

	modport source (output valid, output kind, output elem_type, output decl_length,
		output value_index, output elem_offset, output value_byte, output value_last,
		output status, output elem_count, input ready);
	modport sink (input valid, input kind, input elem_type, input decl_length,
		input value_index, input elem_offset, input value_byte, input value_last,
		input status, input elem_count, output ready);
endinterface

// ----- src/tlv_stream_walker.sv -----
// TLV stream walker: takes one frame byte or an end-of-frame marker per request
// and returns at most one record per request. A value byte comes out tagged with
// its element's type, declared length, index and frame offset; a zero-length
// element gives one record; the end-of-frame marker gives a summary (status,
// element count) and clears the walker for the next frame. A request is taken
// every cycle as long as the record register drains; each request is held in the
// input register and its record, if any, then goes into the record register.
// Bytes past the element area or after a truncation are dropped without a record.
// FRAME_BYTES caps the element area.
`include "tlv_stream_walker_defines.svh"

module tlv_stream_walker #(
	parameter int unsigned FRAME_BYTES = tsw_pkg::FRAME_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tlv_byte_if.sink   byte_ch,
	tlv_rec_if.source  rec_ch
);
	import tsw_pkg::*;

	localparam int unsigned CLAMP = (FRAME_BYTES > FLEN_MAX) ? FLEN_MAX : FRAME_BYTES;
	localparam int unsigned OFS_W = $clog2(CLAMP + 1);
	localparam logic [FLEN_W-1:0] CLAMP_LEN = FLEN_W'(CLAMP);

	// Input stage
	logic              valid_s1;
	logic              op_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [FLEN_W-1:0] flen_s1;

	// Walker state
	phase_t            phase_q, phase_d;
	logic [OFS_W-1:0]  scan_q, scan_d;
	logic [BYTE_W-1:0] type_q, type_d;
	logic [BYTE_W-1:0] len_lo_q, len_lo_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [OFS_W-1:0]  idx_q, idx_d;
	logic [OFS_W-1:0]  start_q, start_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              err_q, err_d;

	// Record register
	logic rec_valid_q;
	rec_t rec_q, rec_d;
	logic produce;

	logic adv_s1, fire_s1;

	logic [FLEN_W-1:0] eff_len;
	logic [OFS_W-1:0]  eff;
	logic [OFS_W-1:0]  remaining;
	logic [OFS_W-1:0]  rem_m1;
	logic [LEN_W-1:0]  len_full;
	logic              len_bad;
	logic              last;

	// Advance the input stage whenever the record register can take a result
	assign adv_s1        = !rec_valid_q || rec_ch.ready;
	assign fire_s1       = valid_s1 && adv_s1;
	assign byte_ch.ready = !valid_s1 || adv_s1;

	// Hold the request in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			op_s1   <= byte_ch.op;
			byte_s1 <= byte_ch.data_byte;
			flen_s1 <= byte_ch.frame_length;
		end
	end

	// Bounds of the element area for this request
	assign eff_len   = (flen_s1 < CLAMP_LEN) ? flen_s1 : CLAMP_LEN;
	assign eff       = OFS_W'(eff_len);
	assign remaining = eff - scan_q;
	assign rem_m1    = remaining - 1'b1;
	assign len_full  = {byte_s1, len_lo_q};
	assign len_bad   = (17'(len_full) > 17'(rem_m1));
	assign last      = ((17'(idx_q) + 17'd1) >= 17'(len_q));

	// Next state and record
	always_comb begin
		phase_d  = phase_q;
		scan_d   = scan_q;
		type_d   = type_q;
		len_lo_d = len_lo_q;
		len_d    = len_q;
		idx_d    = idx_q;
		start_d  = start_q;
		cnt_d    = cnt_q;
		err_d    = err_q;
		produce  = 1'b0;
		rec_d    = '0;

		if (op_s1 == OP_END) begin
			// Report the frame and clear for the next one
			produce          = 1'b1;
			rec_d.kind       = KIND_SUMMARY;
			rec_d.status     = err_q || (scan_q != eff);
			rec_d.elem_count = cnt_q;
			phase_d  = PH_TYPE;
			scan_d   = '0;
			type_d   = '0;
			len_lo_d = '0;
			len_d    = '0;
			idx_d    = '0;
			start_d  = '0;
			cnt_d    = '0;
			err_d    = 1'b0;
		end else if (!err_q && (scan_q < eff)) begin
			unique case (phase_q)
				PH_TYPE: begin
					if (remaining < OFS_W'(HDR_BYTES)) begin
						err_d = 1'b1;
					end else begin
						type_d  = byte_s1;
						start_d = scan_q;
						phase_d = PH_LEN_LO;
						scan_d  = scan_q + 1'b1;
					end
				end
				PH_LEN_LO: begin
					len_lo_d = byte_s1;
					phase_d  = PH_LEN_HI;
					scan_d   = scan_q + 1'b1;
				end
				PH_LEN_HI: begin
					if (len_bad) begin
						err_d = 1'b1;
					end else begin
						if (cnt_q != CNT_MAX) begin
							cnt_d = cnt_q + 1'b1;
						end
						len_d  = len_full;
						idx_d  = '0;
						scan_d = scan_q + 1'b1;
						if (len_full == '0) begin
							produce            = 1'b1;
							rec_d.kind         = KIND_ZERO;
							rec_d.elem_type    = type_q;
							rec_d.decl_length  = len_full;
							rec_d.elem_offset  = IDX_W'(start_q);
							phase_d            = PH_TYPE;
						end else begin
							phase_d = PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					produce            = 1'b1;
					rec_d.kind         = KIND_VALUE;
					rec_d.elem_type    = type_q;
					rec_d.decl_length  = len_q;
					rec_d.value_index  = IDX_W'(idx_q);
					rec_d.elem_offset  = IDX_W'(start_q);
					rec_d.value_byte   = byte_s1;
					rec_d.value_last   = last;
					idx_d  = idx_q + 1'b1;
					scan_d = scan_q + 1'b1;
					if (last) begin
						phase_d = PH_TYPE;
					end
				end
				default: begin
					phase_d = PH_TYPE;
				end
			endcase
		end
	end

	// Advance walker state on each processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			scan_q   <= '0;
			type_q   <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
			idx_q    <= '0;
			start_q  <= '0;
			cnt_q    <= '0;
			err_q    <= 1'b0;
		end else if (fire_s1) begin
			phase_q  <= phase_d;
			scan_q   <= scan_d;
			type_q   <= type_d;
			len_lo_q <= len_lo_d;
			len_q    <= len_d;
			idx_q    <= idx_d;
			start_q  <= start_d;
			cnt_q    <= cnt_d;
			err_q    <= err_d;
		end
	end

	// Load the record register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rec_valid_q <= fire_s1 && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && produce) begin
			rec_q <= rec_d;
		end
	end

	assign rec_ch.valid        = rec_valid_q;
	assign rec_ch.kind         = rec_q.kind;
	assign rec_ch.elem_type    = rec_q.elem_type;
	assign rec_ch.decl_length  = rec_q.decl_length;
	assign rec_ch.value_index  = rec_q.value_index;
	assign rec_ch.elem_offset  = rec_q.elem_offset;
	assign rec_ch.value_byte   = rec_q.value_byte;
	assign rec_ch.value_last   = rec_q.value_last;
	assign rec_ch.status       = rec_q.status;
	assign rec_ch.elem_count   = rec_q.elem_count;

	// A truncation sticks until the end-of-frame request
	`TSW_ASSERT_NEXT(a_err_sticky, err_q && !(fire_s1 && op_s1 == OP_END), err_q, "error flag dropped inside a frame")
	// A summary leaves the walker cleared
	`TSW_ASSERT_NEXT(a_sum_clears, fire_s1 && op_s1 == OP_END, scan_q == '0 && cnt_q == '0 && !err_q && phase_q == PH_TYPE, "walker not cleared after summary")
	// The scan offset never passes the capped frame size
	`TSW_ASSERT_SAME(a_scan_bound, 1'b1, 32'(scan_q) <= CLAMP, "scan offset beyond frame cap")
	// Only value records carry a last flag
	`TSW_ASSERT_SAME(a_last_kind, rec_valid_q && rec_q.value_last, rec_q.kind == KIND_VALUE, "last flag on non-value record")

endmodule

// ----- tb/tlv_stream_walker_tb.sv -----
module tlv_stream_walker_tb;
	import tsw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RAND_REQS   = 600;
	localparam int unsigned SHORT_FRAME = 48;
	localparam int unsigned MAX_REPORTS = 10;

	// One request, plus a typed-in record where the result is obvious
	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] data;
		logic [FLEN_W-1:0] flen;
		logic              typed;
		rec_t              rec;
	} req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlv_byte_if byte_ch();
	tlv_rec_if  rec_ch();

	tlv_stream_walker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_ch(byte_ch),
		.rec_ch (rec_ch)
	);

	always #1 clk = ~clk;

	// Walker state as the testbench tracks it
	phase_t            walk_phase;
	logic [FLEN_W-1:0] walk_offset;
	logic [BYTE_W-1:0] walk_type;
	logic [BYTE_W-1:0] walk_len_lo;
	logic [LEN_W-1:0]  walk_len;
	logic [IDX_W-1:0]  walk_index;
	logic [IDX_W-1:0]  walk_start;
	logic [CNT_W-1:0]  walk_headers;
	logic              walk_error;

	rec_t        pending_recs[$];
	int unsigned mismatches = 0;
	int unsigned reqs_sent = 0;
	int unsigned recs_seen = 0;
	int unsigned frames_sent = 0;
	int unsigned cycles = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;

	function automatic void clear_walker();
		walk_phase   = PH_TYPE;
		walk_offset  = '0;
		walk_type    = '0;
		walk_len_lo  = '0;
		walk_len     = '0;
		walk_index   = '0;
		walk_start   = '0;
		walk_headers = '0;
		walk_error   = 1'b0;
	endfunction

	// Advance the walker by one request; return 1 when it yields a record
	function automatic bit walk_predict(input req_t q, output rec_t r);
		int unsigned eff;
		int unsigned remaining;
		int unsigned len;
		bit          made;
		r = '0;
		made = 1'b0;
		eff = (q.flen < FRAME_BYTES_DEF) ? q.flen : FRAME_BYTES_DEF;
		if (q.op == OP_END) begin
			r.kind = KIND_SUMMARY;
			r.status = walk_error || (walk_offset != eff);
			r.elem_count = walk_headers;
			clear_walker();
			return 1'b1;
		end
		// drop bytes after truncation or past the element area
		if (walk_error || walk_offset >= eff)
			return 1'b0;
		remaining = eff - walk_offset;
		case (walk_phase)
			PH_TYPE: begin
				if (remaining < HDR_BYTES) begin
					walk_error = 1'b1;
					return 1'b0;
				end
				walk_type = q.data;
				walk_start = walk_offset[IDX_W-1:0];
				walk_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				walk_len_lo = q.data;
				walk_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len = 32'({q.data, walk_len_lo});
				// bytes left after this header byte must hold the value
				if (len > remaining - 1) begin
					walk_error = 1'b1;
					return 1'b0;
				end
				if (walk_headers != CNT_MAX)
					walk_headers++;
				walk_len = len[LEN_W-1:0];
				walk_index = '0;
				if (len == 0) begin
					r.kind = KIND_ZERO;
					r.elem_type = walk_type;
					r.elem_offset = walk_start;
					made = 1'b1;
					walk_phase = PH_TYPE;
				end else begin
					walk_phase = PH_VALUE;
				end
			end
			default: begin
				r.kind = KIND_VALUE;
				r.elem_type = walk_type;
				r.decl_length = walk_len;
				r.elem_offset = walk_start;
				r.value_index = walk_index;
				r.value_byte = q.data;
				r.value_last = (walk_index + 32'd1) >= walk_len;
				made = 1'b1;
				walk_index++;
				if (r.value_last)
					walk_phase = PH_TYPE;
			end
		endcase
		walk_offset++;
		return made;
	endfunction

	function automatic rec_t sum_rec(input logic status, input logic [CNT_W-1:0] count);
		rec_t r;
		r = '0;
		r.kind = KIND_SUMMARY;
		r.status = status;
		r.elem_count = count;
		return r;
	endfunction

	function automatic rec_t zero_rec(input logic [BYTE_W-1:0] etype,
		input logic [IDX_W-1:0] offset);
		rec_t r;
		r = '0;
		r.kind = KIND_ZERO;
		r.elem_type = etype;
		r.elem_offset = offset;
		return r;
	endfunction

	function automatic string fmt_rec(input rec_t r);
		return $sformatf("kind %0d type %02h len %04h idx %0d off %0d byte %02h last %0b status %0b count %0d",
			r.kind, r.elem_type, r.decl_length, r.value_index, r.elem_offset,
			r.value_byte, r.value_last, r.status, r.elem_count);
	endfunction

	// Present one request from a falling edge, hold it until taken, then log the expected record
	task automatic send_req(input req_t q);
		rec_t r;
		bit   made;
		while ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid = 1'b0;
			@(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.op = q.op;
		byte_ch.data_byte = q.data;
		byte_ch.frame_length = q.flen;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		made = walk_predict(q, r);
		if (q.typed)
			pending_recs.push_back(q.rec);
		else if (made)
			pending_recs.push_back(r);
		reqs_sent++;
		@(negedge clk);
	endtask

	// Send a frame's bytes, optionally jittering the frame length, then the end marker
	task automatic play_frame(input logic [BYTE_W-1:0] bq[$], input logic [FLEN_W-1:0] flen,
		input bit shaky, input logic [FLEN_W-1:0] end_flen);
		req_t q;
		q = '0;
		foreach (bq[i]) begin
			q.op = OP_DATA;
			q.data = bq[i];
			q.flen = flen;
			if (shaky && $urandom_range(3) == 0)
				q.flen = FLEN_W'($urandom_range(FLEN_MAX));
			send_req(q);
		end
		q.op = OP_END;
		q.data = BYTE_W'($urandom);
		q.flen = end_flen;
		send_req(q);
		frames_sent++;
	endtask

	// Build a mostly well-formed frame of short elements, then maybe damage it
	task automatic random_frame();
		logic [BYTE_W-1:0] bq[$];
		logic [FLEN_W-1:0] end_flen;
		int unsigned       flen;
		int unsigned       room;
		int unsigned       len;
		int unsigned       maxl;
		int unsigned       pick;
		int unsigned       n;
		bit                shaky;
		pick = $urandom_range(99);
		flen = (pick < 85) ? $urandom_range(SHORT_FRAME) : $urandom_range(FLEN_MAX);
		room = (flen <= SHORT_FRAME) ? flen : $urandom_range(SHORT_FRAME);
		while (room >= HDR_BYTES) begin
			maxl = room - HDR_BYTES;
			if (maxl > 8)
				maxl = 8;
			len = ($urandom_range(3) == 0) ? 0 : $urandom_range(maxl);
			bq.push_back(BYTE_W'($urandom));
			bq.push_back(len[7:0]);
			bq.push_back(len[15:8]);
			repeat (len) bq.push_back(BYTE_W'($urandom));
			room -= HDR_BYTES + len;
		end
		// leftover bytes too short for a header
		repeat (room) bq.push_back(BYTE_W'($urandom));
		shaky = 1'b0;
		pick = $urandom_range(99);
		if (pick < 60) begin
			// keep the frame clean
		end else if (pick < 70) begin
			// lead with a header whose length will rarely fit
			n = $urandom_range(16'hFFFF);
			bq.push_front(n[15:8]);
			bq.push_front(n[7:0]);
			bq.push_front(BYTE_W'($urandom));
		end else if (pick < 76) begin
			if (bq.size() != 0)
				bq[$urandom_range(bq.size() - 1)] = BYTE_W'($urandom);
		end else if (pick < 82) begin
			// end the frame early
			repeat ($urandom_range(1, 3))
				if (bq.size() != 0)
					void'(bq.pop_back());
		end else if (pick < 88) begin
			// run past the element area
			repeat ($urandom_range(1, 3)) bq.push_back(BYTE_W'($urandom));
		end else if (pick < 94) begin
			shaky = 1'b1;
		end else begin
			foreach (bq[i]) bq[i] = BYTE_W'($urandom);
		end
		end_flen = FLEN_W'(($urandom_range(9) == 0) ? $urandom_range(FLEN_MAX) : flen);
		play_frame(bq, FLEN_W'(flen), shaky, end_flen);
	endtask

	// Stall the record side at random
	always @(negedge clk) begin
		rec_ch.ready = ($urandom_range(99) >= snk_stall_pct);
	end

	// Check each record taken against the oldest expectation
	always @(posedge clk) begin
		rec_t got;
		rec_t want;
		if (arst_n && rec_ch.valid && rec_ch.ready) begin
			got = {rec_ch.kind, rec_ch.elem_type, rec_ch.decl_length, rec_ch.value_index,
				rec_ch.elem_offset, rec_ch.value_byte, rec_ch.value_last, rec_ch.status,
				rec_ch.elem_count};
			recs_seen++;
			if (pending_recs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected record: %s", fmt_rec(got));
			end else begin
				want = pending_recs.pop_front();
				if (got.kind !== want.kind || got.elem_type !== want.elem_type ||
					got.decl_length !== want.decl_length ||
					got.value_index !== want.value_index ||
					got.elem_offset !== want.elem_offset ||
					got.value_byte !== want.value_byte ||
					got.value_last !== want.value_last || got.status !== want.status ||
					got.elem_count !== want.elem_count) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("record mismatch at cycle %0d", cycles);
						$display("  expected %s", fmt_rec(want));
						$display("  actual   %s", fmt_rec(got));
					end
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d records outstanding", cycles,
				pending_recs.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [BYTE_W-1:0] big[$];
		req_t              dir_tab [26];
		int unsigned       k;
		int unsigned       start;
		byte_ch.valid = 1'b0;
		byte_ch.op = OP_DATA;
		byte_ch.data_byte = '0;
		byte_ch.frame_length = '0;
		rec_ch.ready = 1'b0;
		clear_walker();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty and short end markers, extreme bytes, overlong length,
		// short header room, bytes after truncation and past the frame
		dir_tab = '{
			'{OP_END,  8'hFF, 12'd0,    1'b1, sum_rec(1'b0, 10'd0)},
			'{OP_END,  8'h00, 12'd5,    1'b1, sum_rec(1'b1, 10'd0)},
			'{OP_DATA, 8'hFF, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'h00, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'h00, 12'd4095, 1'b1, zero_rec(8'hFF, 11'd0)},
			'{OP_DATA, 8'h00, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'h02, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'h00, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'hFF, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'h00, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'hA5, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'hFF, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'hFF, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_DATA, 8'h77, 12'd4095, 1'b0, rec_t'('0)},
			'{OP_END,  8'h5A, 12'd4095, 1'b1, sum_rec(1'b1, 10'd2)},
			'{OP_DATA, 8'h01, 12'd5,    1'b0, rec_t'('0)},
			'{OP_DATA, 8'h00, 12'd5,    1'b0, rec_t'('0)},
			'{OP_DATA, 8'h00, 12'd5,    1'b1, zero_rec(8'h01, 11'd0)},
			'{OP_DATA, 8'h3C, 12'd5,    1'b0, rec_t'('0)},
			'{OP_END,  8'h00, 12'd5,    1'b1, sum_rec(1'b1, 10'd1)},
			'{OP_DATA, 8'h09, 12'd4,    1'b0, rec_t'('0)},
			'{OP_DATA, 8'h01, 12'd4,    1'b0, rec_t'('0)},
			'{OP_DATA, 8'h00, 12'd4,    1'b0, rec_t'('0)},
			'{OP_DATA, 8'hAB, 12'd4,    1'b0, rec_t'('0)},
			'{OP_DATA, 8'hEE, 12'd4,    1'b0, rec_t'('0)},
			'{OP_END,  8'h00, 12'd4,    1'b1, sum_rec(1'b0, 10'd1)}
		};
		foreach (dir_tab[i])
			send_req(dir_tab[i]);

		// One clean frame: a long value reaching high indexes, then zero-length elements
		big.push_back(BYTE_W'($urandom));
		big.push_back(8'h40);
		big.push_back(8'h01);
		repeat (320) big.push_back(BYTE_W'($urandom));
		repeat (25) begin
			big.push_back(BYTE_W'($urandom));
			big.push_back(8'h00);
			big.push_back(8'h00);
		end
		play_frame(big, 12'd398, 1'b0, 12'd398);

		// Random frames under each idling mix
		for (k = 0; k < 4; k++) begin
			case (k)
				0: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 56;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					snk_stall_pct = 56;
				end
				default: begin
					src_idle_pct = 30;
					snk_stall_pct = 30;
				end
			endcase
			start = reqs_sent;
			while (reqs_sent - start < RAND_REQS / 4)
				random_frame();
		end
		byte_ch.valid = 1'b0;

		// Drain, then give any stray record time to show up
		while (pending_recs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("walked %0d frames in %0d requests, %0d records checked",
			frames_sent, reqs_sent, recs_seen);
		$display("%0d mismatches over %0d cycles", mismatches, cycles);
		if (mismatches == 0 && pending_recs.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
